>>> design/xaox_pkg.sv
// shared types, constants and a helper function for the xoroshiro128aox generator
package xaox_pkg;

  localparam int WORD_W    = 64;
  localparam int HALF_W    = WORD_W / 2;
  localparam int FRAC_W    = 53;
  localparam int FRAC_LSB  = WORD_W - FRAC_W;
  localparam int KIND_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int JUMP_STEPS = 2 * WORD_W;
  localparam int JCNT_W    = $clog2(JUMP_STEPS);

  // operation codes carried by the request
  localparam logic [KIND_W-1:0] KIND_NEXT      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SEED      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LOAD      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_JUMP      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LONG_JUMP = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_LO      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_HI      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_JUMP_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_JUMP_HI = 2'd3;

  // splitmix64 constants
  localparam logic [WORD_W-1:0] SM_GAMMA = 64'h9e3779b97f4a7c15;
  localparam logic [WORD_W-1:0] SM_MUL1  = 64'hbf58476d1ce4e5b9;
  localparam logic [WORD_W-1:0] SM_MUL2  = 64'h94d049bb133111eb;
  localparam int SM_SHIFT1 = 30;
  localparam int SM_SHIFT2 = 27;
  localparam int SM_SHIFT3 = 31;

  // xoroshiro rotations and shifts
  localparam int ROT_OUT = 7;
  localparam int ROT_A   = 24;
  localparam int SHL_B   = 16;
  localparam int ROT_C   = 37;

  // partial products of one 64 x 64 multiply, low half kept
  localparam logic [1:0] MUL_PH_LL   = 2'd0;
  localparam logic [1:0] MUL_PH_HL   = 2'd1;
  localparam logic [1:0] MUL_PH_LAST = 2'd2;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_NEXT,
    DP_LOAD,
    DP_PASS,
    DP_SEED_START,
    DP_XS30,
    DP_MUL,
    DP_XS27,
    DP_FIN0,
    DP_FIN1,
    DP_JUMP_START,
    DP_JUMP_STEP,
    DP_JUMP_END
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] mul_phase;
    logic       mul_sel;   // 0 first splitmix multiplier, 1 second
    logic       long_sel;  // jump start: use long-jump polynomial
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;   // result register empty or drained this cycle
    logic jump_last;  // last of the jump steps
  } dp_stat_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int unsigned k);
    rotl = (x << k) | (x >> (WORD_W - k));
  endfunction

endpackage

>>> design/xaox_req_if.sv
// request channel: operation kind and its operands
interface xaox_req_if;
  import xaox_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [WORD_W-1:0] seed_value;
  logic [WORD_W-1:0] load_word0;
  logic [WORD_W-1:0] load_word1;

  modport source (output valid, kind, seed_value, load_word0, load_word1, input ready);
  modport sink   (input valid, kind, seed_value, load_word0, load_word1, output ready);
endinterface

>>> design/xaox_rsp_if.sv
// result channel: random word, fraction and state words
interface xaox_rsp_if;
  import xaox_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] random_word;
  logic [FRAC_W-1:0] unit_fraction;
  logic [WORD_W-1:0] state_word0_out;
  logic [WORD_W-1:0] state_word1_out;

  modport source (output valid, random_word, unit_fraction, state_word0_out, state_word1_out,
                  input ready);
  modport sink   (input valid, random_word, unit_fraction, state_word0_out, state_word1_out,
                  output ready);
endinterface

>>> design/xaox_ctrl.sv
// controller: accepts requests and sequences seeding and jumps
module xaox_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  input  logic [xaox_pkg::KIND_W-1:0]    req_kind,
  output logic                           req_ready,
  input  xaox_pkg::dp_stat_t             stat,
  output xaox_pkg::dp_cmd_t              cmd
);
  import xaox_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_XS30,
    ST_MUL_A,
    ST_XS27,
    ST_MUL_B,
    ST_FIN,
    ST_JUMP,
    ST_JUMP_END
  } state_t;

  state_t     state;
  logic [1:0] phase;
  logic       half;
  logic       accept;

  assign req_ready = (state == ST_IDLE) && stat.out_free;
  assign accept    = req_valid && req_ready;

  always_comb begin
    cmd = '{op: DP_NOP, mul_phase: phase, mul_sel: 1'b0, long_sel: 1'b0};
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req_kind)
            KIND_NEXT:      cmd.op = DP_NEXT;
            KIND_SEED:      cmd.op = DP_SEED_START;
            KIND_LOAD:      cmd.op = DP_LOAD;
            KIND_JUMP:      cmd.op = DP_JUMP_START;
            KIND_LONG_JUMP: begin
              cmd.op       = DP_JUMP_START;
              cmd.long_sel = 1'b1;
            end
            default:        cmd.op = DP_PASS;
          endcase
        end
      end
      ST_XS30:     cmd.op = DP_XS30;
      ST_MUL_A:    cmd.op = DP_MUL;
      ST_XS27:     cmd.op = DP_XS27;
      ST_MUL_B: begin
        cmd.op      = DP_MUL;
        cmd.mul_sel = 1'b1;
      end
      ST_FIN:      cmd.op = half ? DP_FIN1 : DP_FIN0;
      ST_JUMP:     cmd.op = DP_JUMP_STEP;
      ST_JUMP_END: cmd.op = DP_JUMP_END;
      default:     cmd.op = DP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= MUL_PH_LL;
      half  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (req_kind)
              KIND_SEED: begin
                state <= ST_XS30;
                half  <= 1'b0;
              end
              KIND_JUMP, KIND_LONG_JUMP: state <= ST_JUMP;
              default:                   state <= ST_IDLE;
            endcase
          end
        end
        ST_XS30: begin
          state <= ST_MUL_A;
          phase <= MUL_PH_LL;
        end
        ST_MUL_A: begin
          if (phase == MUL_PH_LAST) begin
            state <= ST_XS27;
            phase <= MUL_PH_LL;
          end else begin
            phase <= phase + 2'd1;
          end
        end
        ST_XS27: begin
          state <= ST_MUL_B;
          phase <= MUL_PH_LL;
        end
        ST_MUL_B: begin
          if (phase == MUL_PH_LAST) begin
            state <= ST_FIN;
            phase <= MUL_PH_LL;
          end else begin
            phase <= phase + 2'd1;
          end
        end
        ST_FIN: begin
          if (half) begin
            state <= ST_IDLE;
            half  <= 1'b0;
          end else begin
            state <= ST_XS30;
            half  <= 1'b1;
          end
        end
        ST_JUMP: begin
          if (stat.jump_last) state <= ST_JUMP_END;
        end
        ST_JUMP_END: state <= ST_IDLE;
        default:     state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> design/xaox_dp.sv
// datapath: generator state, splitmix unit, jump accumulators and result register
module xaox_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  xaox_pkg::dp_cmd_t                 cmd,
  output xaox_pkg::dp_stat_t                stat,
  input  logic [xaox_pkg::WORD_W-1:0]       seed_value,
  input  logic [xaox_pkg::WORD_W-1:0]       load_word0,
  input  logic [xaox_pkg::WORD_W-1:0]       load_word1,
  input  logic                              cfg_write_en,
  input  logic [xaox_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [xaox_pkg::WORD_W-1:0]       cfg_data,
  xaox_rsp_if.source                        result
);
  import xaox_pkg::*;

  // configuration
  logic [WORD_W-1:0] jump_lo, jump_hi, long_lo, long_hi;

  // generator state and working registers
  logic [WORD_W-1:0] s0, s1, s0_next, s1_next;
  logic [WORD_W-1:0] acc0, acc1;
  logic [JCNT_W-1:0] jcnt;
  logic              long_sel;
  logic [WORD_W-1:0] z, m, prod;

  // result register
  logic              out_valid;
  logic [WORD_W-1:0] out_word, out_s0, out_s1;
  logic              out_load;
  logic [WORD_W-1:0] out_word_next;

  // xoroshiro step
  logic [WORD_W-1:0] t, word, adv0, adv1;
  assign word = (s0 & s1) | rotl(s0 ^ s1, ROT_OUT);
  assign t    = s0 ^ s1;
  assign adv0 = rotl(s0, ROT_A) ^ t ^ (t << SHL_B);
  assign adv1 = rotl(t, ROT_C);

  // jump polynomial bit
  logic [2*WORD_W-1:0] poly;
  logic                poly_bit;
  assign poly     = long_sel ? {long_hi, long_lo} : {jump_hi, jump_lo};
  assign poly_bit = poly[jcnt];

  // shared 32 x 32 multiplier
  logic [WORD_W-1:0] mconst;
  logic [HALF_W-1:0] mul_a, mul_b;
  logic [WORD_W-1:0] pp;
  assign mconst = cmd.mul_sel ? SM_MUL2 : SM_MUL1;
  assign mul_a  = (cmd.mul_phase == MUL_PH_HL) ? m[WORD_W-1:HALF_W] : m[HALF_W-1:0];
  assign mul_b  = (cmd.mul_phase == MUL_PH_LAST) ? mconst[WORD_W-1:HALF_W]
                                                  : mconst[HALF_W-1:0];
  assign pp     = WORD_W'(mul_a) * WORD_W'(mul_b);

  logic [HALF_W-1:0] hi_sum;
  assign hi_sum = prod[WORD_W-1:HALF_W] + pp[HALF_W-1:0];

  logic [WORD_W-1:0] z_step, m_fin;
  assign z_step = z + SM_GAMMA;
  assign m_fin  = m ^ (m >> SM_SHIFT3);

  always_comb begin
    s0_next       = s0;
    s1_next       = s1;
    out_load      = 1'b0;
    out_word_next = '0;
    case (cmd.op)
      DP_NEXT: begin
        s0_next       = adv0;
        s1_next       = adv1;
        out_load      = 1'b1;
        out_word_next = word;
      end
      DP_LOAD: begin
        s0_next  = load_word0;
        s1_next  = load_word1;
        out_load = 1'b1;
      end
      DP_PASS:  out_load = 1'b1;
      DP_FIN0:  s0_next = m_fin;
      DP_FIN1: begin
        s1_next  = m_fin;
        out_load = 1'b1;
      end
      DP_JUMP_STEP: begin
        s0_next = adv0;
        s1_next = adv1;
      end
      DP_JUMP_END: begin
        s0_next  = acc0;
        s1_next  = acc1;
        out_load = 1'b1;
      end
      default: ;
    endcase
  end

  assign stat.out_free  = !out_valid || result.ready;
  assign stat.jump_last = (jcnt == JCNT_W'(JUMP_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      jump_lo <= '0;
      jump_hi <= '0;
      long_lo <= '0;
      long_hi <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_JUMP_LO:      jump_lo <= cfg_data;
        CFG_JUMP_HI:      jump_hi <= cfg_data;
        CFG_LONG_JUMP_LO: long_lo <= cfg_data;
        CFG_LONG_JUMP_HI: long_hi <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0        <= '0;
      s1        <= '0;
      acc0      <= '0;
      acc1      <= '0;
      jcnt      <= '0;
      long_sel  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s0 <= s0_next;
      s1 <= s1_next;
      if (out_load)          out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
      case (cmd.op)
        DP_JUMP_START: begin
          acc0     <= '0;
          acc1     <= '0;
          jcnt     <= '0;
          long_sel <= cmd.long_sel;
        end
        DP_JUMP_STEP: begin
          if (poly_bit) begin
            acc0 <= acc0 ^ s0;
            acc1 <= acc1 ^ s1;
          end
          jcnt <= jcnt + JCNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  // splitmix working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_SEED_START: begin
        z <= seed_value + SM_GAMMA;
        m <= seed_value + SM_GAMMA;
      end
      DP_XS30: m <= m ^ (m >> SM_SHIFT1);
      DP_XS27: m <= m ^ (m >> SM_SHIFT2);
      DP_MUL: begin
        case (cmd.mul_phase)
          MUL_PH_LL:   prod <= pp;
          MUL_PH_HL:   prod <= {hi_sum, prod[HALF_W-1:0]};
          MUL_PH_LAST: m    <= {hi_sum, prod[HALF_W-1:0]};
          default: ;
        endcase
      end
      DP_FIN0: begin
        z <= z_step;
        m <= z_step;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word <= out_word_next;
      out_s0   <= s0_next;
      out_s1   <= s1_next;
    end
  end

  assign result.valid           = out_valid;
  assign result.random_word     = out_word;
  assign result.unit_fraction   = out_word[WORD_W-1:FRAC_LSB];
  assign result.state_word0_out = out_s0;
  assign result.state_word1_out = out_s1;

endmodule

>>> design/xoroshiro128_aox_generator.sv
// top level of the xoroshiro128aox generator with seeding, loading and jumps
//
//   channel   dir  handshake      contents
//   request   in   valid/ready    kind, seed_value, load_word0, load_word1
//   result    out  valid/ready    random_word, unit_fraction, state_word0_out,
//                                 state_word1_out
//   cfg       in   cfg_write_en   cfg_index, cfg_data (jump polynomial words)
//
// next, load and unused kinds finish in the accept cycle: one request per cycle while the result drains
// seed runs through one shared 32x32 multiplier doing three partial
// products for each of the four splitmix multiplies
// jump and long jump make one advance step per polynomial bit
// reset clears the state words, polynomial registers and the result valid flag
// a stalled result blocks new requests only while the result register is full
module xoroshiro128_aox_generator (
  input  logic                            clk,
  input  logic                            rst,
  xaox_req_if.sink                        request,
  xaox_rsp_if.source                      result,
  input  logic                            cfg_write_en,
  input  logic [xaox_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [xaox_pkg::WORD_W-1:0]     cfg_data
);
  import xaox_pkg::*;

  // command from the controller, status back from the datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // request acceptance and operation sequencing
  xaox_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_kind  (request.kind),
    .req_ready (request.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // state, splitmix unit, jump accumulation and result register
  xaox_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .seed_value   (request.seed_value),
    .load_word0   (request.load_word0),
    .load_word1   (request.load_word1),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result       (result)
  );

endmodule

>>> test/xoroshiro128_aox_generator_tb.sv
// testbench for the xoroshiro128aox generator: random and directed requests checked against a predictor
module xoroshiro128_aox_generator_tb;
  import xaox_pkg::*;

  // kinds the block leaves without effect
  localparam logic [KIND_W-1:0] KIND_SPARE_5 = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

  localparam int WATCHDOG_LIMIT = 3000; // longest quiet stretch: hold-off + jump + gap
  localparam int LONG_HOLD      = 300;  // receiver hold-off that backs up the block
  localparam int DRAIN_CYCLES   = JUMP_STEPS + 20;

  // one request as the sender queues it
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] seed;
    logic [WORD_W-1:0] w0;
    logic [WORD_W-1:0] w1;
  } gen_op_t;

  // one result as the block should deliver it
  typedef struct packed {
    logic [WORD_W-1:0] rword;
    logic [FRAC_W-1:0] frac;
    logic [WORD_W-1:0] s0;
    logic [WORD_W-1:0] s1;
  } draw_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0] cfg_data;

  xaox_req_if req_ch ();
  xaox_rsp_if rsp_ch ();

  xoroshiro128_aox_generator dut (
    .clk          (clk),
    .rst          (rst),
    .request      (req_ch),
    .result       (rsp_ch),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted generator state and polynomial registers
  logic [WORD_W-1:0] gs0, gs1;
  logic [WORD_W-1:0] poly_jump_lo, poly_jump_hi, poly_long_lo, poly_long_hi;

  gen_op_t pending[$];        // requests not yet offered
  draw_t   expected_draws[$]; // results owed by the block, oldest first

  int req_sent, req_taken;    // offered and accepted request counts
  int results_checked, mismatches, settings_done;
  int kind_seen [8];
  int hold_asks, hold_done;   // long receiver hold-offs asked for and started

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic logic [WORD_W-1:0] rot64(logic [WORD_W-1:0] x, int unsigned k);
    logic [2*WORD_W-1:0] both;
    both = {x, x} << k;
    return both[2*WORD_W-1:WORD_W];
  endfunction

  // splitmix64 finalizer
  function automatic logic [WORD_W-1:0] sm_mix(logic [WORD_W-1:0] z);
    z = (z ^ (z >> 30)) * SM_MUL1;
    z = (z ^ (z >> 27)) * SM_MUL2;
    return z ^ (z >> 31);
  endfunction

  // scrambled word of the current state, then one xoroshiro step
  function automatic logic [WORD_W-1:0] xo_advance();
    logic [WORD_W-1:0] word, t;
    word = (gs0 & gs1) | rot64(gs0 ^ gs1, 7);
    t    = gs0 ^ gs1;
    gs0  = rot64(gs0, 24) ^ t ^ (t << 16);
    gs1  = rot64(t, 37);
    return word;
  endfunction

  // polynomial jump: xor-accumulate the state wherever a bit is set, low word first
  function automatic void xo_jump(logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi);
    logic [2*WORD_W-1:0] poly;
    logic [WORD_W-1:0] acc0, acc1;
    poly = {hi, lo};
    acc0 = '0;
    acc1 = '0;
    for (int i = 0; i < JUMP_STEPS; i++) begin
      if (poly[i]) begin
        acc0 ^= gs0;
        acc1 ^= gs1;
      end
      void'(xo_advance());
    end
    gs0 = acc0;
    gs1 = acc1;
  endfunction

  function automatic draw_t xaox_predict(gen_op_t op);
    draw_t d;
    logic [WORD_W-1:0] z;
    d.rword = '0;
    case (op.kind)
      KIND_NEXT: begin
        d.rword = xo_advance();
      end
      KIND_SEED: begin
        z   = op.seed + SM_GAMMA;
        gs0 = sm_mix(z);
        z   = z + SM_GAMMA;
        gs1 = sm_mix(z);
      end
      KIND_LOAD: begin
        gs0 = op.w0;
        gs1 = op.w1;
      end
      KIND_JUMP: begin
        xo_jump(poly_jump_lo, poly_jump_hi);
      end
      KIND_LONG_JUMP: begin
        xo_jump(poly_long_lo, poly_long_hi);
      end
      default: begin
      end
    endcase
    d.frac = d.rword[WORD_W-1:FRAC_LSB];
    d.s0   = gs0;
    d.s1   = gs1;
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // reporting and checking
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(string line);
    $display("MISMATCH: %s", line);
    mismatches++;
  endtask

  task automatic check_draw(draw_t want, draw_t got);
    if (got.rword !== want.rword)
      flag_mismatch($sformatf("result %0d random_word expected %h got %h",
                              results_checked, want.rword, got.rword));
    if (got.frac !== want.frac)
      flag_mismatch($sformatf("result %0d unit_fraction expected %h got %h",
                              results_checked, want.frac, got.frac));
    if (got.s0 !== want.s0)
      flag_mismatch($sformatf("result %0d state_word0_out expected %h got %h",
                              results_checked, want.s0, got.s0));
    if (got.s1 !== want.s1)
      flag_mismatch($sformatf("result %0d state_word1_out expected %h got %h",
                              results_checked, want.s1, got.s1));
  endtask

  // ---------------------------------------------------------------------------
  // idle lengths: mostly short, a few long, none at all in steady stretches
  // ---------------------------------------------------------------------------

  function automatic int idle_len(bit steady);
    int p;
    if (steady)
      return 0;
    p = $urandom_range(0, 99);
    if (p < 60)
      return 0;
    if (p < 88)
      return $urandom_range(1, 3);
    if (p < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: inputs change on the falling edge
  // ---------------------------------------------------------------------------

  int send_gap;
  bit send_steady;

  always @(negedge clk) begin
    logic    nv;
    gen_op_t op;
    if (!rst) begin
      nv = req_ch.valid;
      // offered request went through at the last rising edge
      if (nv && req_taken == req_sent)
        nv = 1'b0;
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending.size() > 0) begin
          op = pending.pop_front();
          req_ch.kind       <= op.kind;
          req_ch.seed_value <= op.seed;
          req_ch.load_word0 <= op.w0;
          req_ch.load_word1 <= op.w1;
          req_sent++;
          nv = 1'b1;
          if ($urandom_range(0, 63) == 0)
            send_steady = !send_steady;
          send_gap = idle_len(send_steady);
        end
      end
      req_ch.valid <= nv;
    end
  end

  // ---------------------------------------------------------------------------
  // result receiver: random stalls plus the occasional long hold-off
  // ---------------------------------------------------------------------------

  int recv_gap, hold_left;
  bit recv_steady;

  always @(negedge clk) begin
    if (!rst) begin
      if (hold_left == 0 && hold_asks != hold_done) begin
        hold_left = LONG_HOLD;
        hold_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        if ($urandom_range(0, 63) == 0)
          recv_steady = !recv_steady;
        recv_gap = idle_len(recv_steady);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: sample both channels on the rising edge, predict, compare
  // ---------------------------------------------------------------------------

  int quiet_cycles;

  always @(posedge clk) begin
    bit      moved;
    gen_op_t op;
    draw_t   got;
    if (!rst) begin
      moved = 1'b0;
      // predict first so a same-edge result still finds its expectation
      if (req_ch.valid && req_ch.ready) begin
        op = '{req_ch.kind, req_ch.seed_value, req_ch.load_word0, req_ch.load_word1};
        expected_draws = {expected_draws, xaox_predict(op)};
        kind_seen[op.kind]++;
        req_taken++;
        moved = 1'b1;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = '{rsp_ch.random_word, rsp_ch.unit_fraction,
                rsp_ch.state_word0_out, rsp_ch.state_word1_out};
        if (expected_draws.size() == 0)
          flag_mismatch($sformatf("unexpected result, random_word %h state %h %h",
                                  got.rword, got.s0, got.s1));
        else
          check_draw(expected_draws.pop_front(), got);
        results_checked++;
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 quiet_cycles, expected_draws.size());
        $display("** xoroshiro128_aox_generator: FAILED **");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void queue_op(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] seed,
                                   logic [WORD_W-1:0] w0, logic [WORD_W-1:0] w1);
    gen_op_t op;
    op      = '{kind, seed, w0, w1};
    pending = {pending, op};
  endfunction

  // 64-bit value leaning toward the extremes now and then
  function automatic logic [WORD_W-1:0] rand_word();
    int p;
    p = $urandom_range(0, 19);
    if (p == 0)
      return '0;
    if (p == 1)
      return '1;
    return {$urandom, $urandom};
  endfunction

  // mostly next requests so the state walks far between reseeds
  function automatic gen_op_t random_op();
    gen_op_t op;
    int p;
    op.seed = rand_word();
    op.w0   = rand_word();
    op.w1   = rand_word();
    p = $urandom_range(0, 99);
    if (p < 76)
      op.kind = KIND_NEXT;
    else if (p < 83)
      op.kind = KIND_SEED;
    else if (p < 90)
      op.kind = KIND_LOAD;
    else if (p < 94)
      op.kind = KIND_JUMP;
    else if (p < 97)
      op.kind = KIND_LONG_JUMP;
    else if (p == 97)
      op.kind = KIND_SPARE_5;
    else if (p == 98)
      op.kind = KIND_SPARE_6;
    else
      op.kind = KIND_SPARE_7;
    return op;
  endfunction

  // block is idle once every request is in and every result is out
  task automatic wait_idle();
    do
      @(negedge clk);
    while (pending.size() != 0 || req_taken != req_sent || expected_draws.size() != 0);
  endtask

  // random requests; spare kinds ride along but do not count
  task automatic send_random(int count);
    gen_op_t op;
    int made;
    made = 0;
    while (made < count) begin
      op = random_op();
      pending = {pending, op};
      if (op.kind <= KIND_LONG_JUMP)
        made++;
    end
    wait_idle();
  endtask

  // write all four polynomial words, only while idle
  task automatic program_polys(logic [WORD_W-1:0] jl, logic [WORD_W-1:0] jh,
                               logic [WORD_W-1:0] ll, logic [WORD_W-1:0] lh);
    logic [WORD_W-1:0]    vals [4];
    logic [CFG_IDX_W-1:0] idxs [4];
    vals = '{jl, jh, ll, lh};
    idxs = '{CFG_JUMP_LO, CFG_JUMP_HI, CFG_LONG_JUMP_LO, CFG_LONG_JUMP_HI};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_write_en <= 1'b1;
      cfg_index    <= idxs[i];
      cfg_data     <= vals[i];
    end
    @(negedge clk);
    cfg_write_en <= 1'b0;
    poly_jump_lo = jl;
    poly_jump_hi = jh;
    poly_long_lo = ll;
    poly_long_hi = lh;
    settings_done++;
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin
    logic [WORD_W-1:0] msb_only;
    msb_only = {1'b1, {(WORD_W-1){1'b0}}};

    // every input known from time zero
    rst               = 1'b1;
    cfg_write_en      = 1'b0;
    cfg_index         = CFG_JUMP_LO;
    cfg_data          = '0;
    req_ch.valid      = 1'b0;
    req_ch.kind       = KIND_NEXT;
    req_ch.seed_value = '0;
    req_ch.load_word0 = '0;
    req_ch.load_word1 = '0;
    rsp_ch.ready      = 1'b0;

    // predictor reset state
    gs0 = '0;
    gs1 = '0;
    poly_jump_lo = '0;
    poly_jump_hi = '0;
    poly_long_lo = '0;
    poly_long_hi = '0;

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // directed, polynomials still at reset zero
    queue_op(KIND_NEXT, '0, '0, '0);                     // all-zero state stays zero
    queue_op(KIND_SPARE_5, '1, '1, '1);                  // spare kinds do nothing
    queue_op(KIND_SPARE_6, {$urandom, $urandom}, '1, '0);
    queue_op(KIND_SPARE_7, '0, '0, '1);
    queue_op(KIND_LOAD, '0, '1, '1);                     // load both all ones
    queue_op(KIND_NEXT, '0, '0, '0);
    queue_op(KIND_LOAD, '1, msb_only, 64'd1);            // top and bottom bits alone
    queue_op(KIND_NEXT, '1, '1, '1);
    queue_op(KIND_SEED, '0, '1, '1);                     // seed of zero
    queue_op(KIND_NEXT, '0, '0, '0);
    queue_op(KIND_SEED, '1, '0, '0);                     // seed of all ones
    queue_op(KIND_NEXT, '0, '0, '0);
    queue_op(KIND_JUMP, '0, '0, '0);                     // zero polynomial clears state
    queue_op(KIND_NEXT, '0, '0, '0);
    queue_op(KIND_SEED, {$urandom, $urandom}, '0, '0);
    queue_op(KIND_LONG_JUMP, '0, '0, '0);
    queue_op(KIND_LOAD, '1, '0, '0);                     // explicit all-zero load
    queue_op(KIND_NEXT, '0, '0, '0);
    wait_idle();

    // polynomials all ones: every step accumulates
    program_polys('1, '1, '1, '1);
    queue_op(KIND_LOAD, '0, {$urandom, $urandom}, {$urandom, $urandom});
    queue_op(KIND_JUMP, '0, '0, '0);
    queue_op(KIND_LONG_JUMP, '0, '0, '0);
    send_random(340);

    // single taps at the word edges
    program_polys(64'd1, msb_only, msb_only, 64'd1);
    queue_op(KIND_SEED, {$urandom, $urandom}, '0, '0);
    queue_op(KIND_JUMP, '0, '0, '0);
    queue_op(KIND_LONG_JUMP, '0, '0, '0);
    send_random(340);

    // random polynomials; one chunk runs against a long receiver hold-off
    for (int ph = 0; ph < 2; ph++) begin
      program_polys({$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom});
      for (int ch = 0; ch < 5; ch++) begin
        if (ph == 0 && ch == 2)
          hold_asks++;
        send_random(68);
      end
    end

    // back to zero polynomials by an explicit write
    program_polys('0, '0, '0, '0);
    send_random(340);

    // let anything stray show up before closing
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_draws.size() != 0)
      flag_mismatch($sformatf("%0d results never delivered", expected_draws.size()));

    $display("run covered %0d requests: next %0d, seed %0d, load %0d, jump %0d, long jump %0d, "
             , req_taken, kind_seen[KIND_NEXT], kind_seen[KIND_SEED], kind_seen[KIND_LOAD],
             kind_seen[KIND_JUMP], kind_seen[KIND_LONG_JUMP]);
    $display("spare kinds %0d; %0d results compared under %0d polynomial settings, %0d mismatches",
             kind_seen[KIND_SPARE_5] + kind_seen[KIND_SPARE_6] + kind_seen[KIND_SPARE_7],
             results_checked, settings_done + 1, mismatches);
    if (mismatches == 0)
      $display("** xoroshiro128_aox_generator: PASSED **");
    else
      $display("** xoroshiro128_aox_generator: FAILED **");
    $finish;
  end

endmodule
